// ===== hw/rtl/btk_pkg.sv =====
// ----------------------------------------------------------------------------
// btk_pkg: shared types and constants of the bounded top-k ranked list
// Holds the entry layout, the result word, the mode and cell command codes
// and the ranking compare used by every cell of the list.
// ----------------------------------------------------------------------------
package btk_pkg;

    // Input item modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // List limit after reset
    localparam logic [6:0] MAX_KEPT_RESET = 7'd64;

    // One stored match
    typedef struct packed {
        logic [6:0]  score;
        logic [1:0]  kind;
        logic [31:0] id;
        logic [3:0]  tag;
    } entry_t;

    // One result word
    typedef struct packed {
        logic        valid_res;
        logic [5:0]  rank;
        logic [6:0]  out_score;
        logic [1:0]  out_kind;
        logic [31:0] out_entry_id;
        logic [3:0]  out_tag;
        logic [6:0]  held_count;
        logic        truncated;
        logic        last;
    } res_word_t;

    // Commands broadcast to the cell row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_EVAL   = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_ctl_t;

    // Tie rank of a match kind: exact, alias, fuzzy, then the unused code
    function automatic logic [1:0] kind_priority(input logic [1:0] kind);
        return kind + 2'd1;
    endfunction

    // True when a ranks strictly ahead of b
    function automatic logic goes_before(input entry_t a, input entry_t b);
        logic [1:0] pa;
        logic [1:0] pb;
        pa = kind_priority(a.kind);
        pb = kind_priority(b.kind);
        if (a.score != b.score) begin
            return a.score > b.score;
        end
        if (pa != pb) begin
            return pa > pb;
        end
        return a.id < b.id;
    endfunction

endpackage

// ===== hw/rtl/btk_if.sv =====
// ----------------------------------------------------------------------------
// btk_if: valid/ready channels of the ranked list
// Request channel carries one offered match or command, result channel one
// result word per handshake.
// ----------------------------------------------------------------------------
interface btk_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [6:0]  score;
    logic [1:0]  kind_code;
    logic [31:0] item_id;
    logic [3:0]  key_tag;

    modport source (output valid, output mode, output score, output kind_code,
                    output item_id, output key_tag, input ready);
    modport sink   (input valid, input mode, input score, input kind_code,
                    input item_id, input key_tag, output ready);
endinterface

interface btk_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [5:0]  rank;
    logic [6:0]  out_score;
    logic [1:0]  out_kind;
    logic [31:0] out_entry_id;
    logic [3:0]  out_tag;
    logic [6:0]  held_count;
    logic        truncated;
    logic        last;

    modport source (output valid, output valid_res, output rank, output out_score,
                    output out_kind, output out_entry_id, output out_tag,
                    output held_count, output truncated, output last,
                    input ready);
    modport sink   (input valid, input valid_res, input rank, input out_score,
                    input out_kind, input out_entry_id, input out_tag,
                    input held_count, input truncated, input last,
                    output ready);
endinterface

// ===== hw/rtl/btk_cell.sv =====
// ----------------------------------------------------------------------------
// btk_cell: one slot of the sorted list
// Compares the offered match with its own entry, then either holds, takes
// the match, takes its left neighbor (shift down on insert) or takes its
// right neighbor / the head entry (rotate on read-out).
// ----------------------------------------------------------------------------
module btk_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  btk_pkg::cell_ctl_t  ctl,
    input  logic [CNT_W-1:0]    held,
    input  btk_pkg::entry_t     left_entry,
    input  logic                left_ahead,
    input  btk_pkg::entry_t     right_entry,
    input  btk_pkg::entry_t     head_entry,
    output btk_pkg::entry_t     entry,
    output logic                ahead
);

    btk_pkg::entry_t entry_reg;
    btk_pkg::entry_t entry_next;
    logic            ahead_reg;
    logic            ahead_next;
    logic            is_empty;
    logic            is_tail;

    // Slot position against the fill level
    assign is_empty = CNT_W'(IDX) >= held;
    assign is_tail  = CNT_W'(IDX + 1) == held;

    // Pick the next entry and flag
    always_comb
    begin
        entry_next = entry_reg;
        ahead_next = ahead_reg;
        case (ctl.op)
            btk_pkg::CELL_EVAL:
            begin
                ahead_next = is_empty || btk_pkg::goes_before(ctl.item, entry_reg);
            end
            btk_pkg::CELL_INSERT:
            begin
                if (left_ahead)
                begin
                    entry_next = left_entry;
                end
                else if (ahead_reg)
                begin
                    entry_next = ctl.item;
                end
            end
            btk_pkg::CELL_ROTATE:
            begin
                entry_next = is_tail ? head_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the slot contents
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        ahead_reg <= ahead_next;
    end

    assign entry = entry_reg;
    assign ahead = ahead_reg;

endmodule

// ===== hw/rtl/bounded_top_k_ranked_list.sv =====
// ----------------------------------------------------------------------------
// bounded_top_k_ranked_list: sorted list of the best scored matches
// A row of CAPACITY cells keeps the list best first; a small sequencer
// accepts items, drives the row and loads the result register.
//
//   channel   dir   handshake      word
//   req       in    valid/ready    mode, score, kind_code, item_id, key_tag
//   res       out   valid/ready    valid_res, rank, entry fields, held_count,
//                                  truncated, last
//   cfg       in    cfg_write      cfg_data = max_kept
//
// Insert: accept, compare in every cell, shift the row; requests wait meanwhile.
// Read-out: accept, then one word per cycle while the result register is free,
// held entries words, the row rotating so the head cell always shows the next
// entry. Clear, empty read and unused mode: accept, then one word.
// Reset clears control state and counters at once; stored entries are not
// cleared, only entries below the fill level are ever read.
// A stalled result register holds the sequencer in its emitting state.
// ----------------------------------------------------------------------------
module bounded_top_k_ranked_list #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [6:0]      cfg_data,
    btk_req_if.sink         req,
    btk_res_if.source       res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVAL   = 5'b00010,
        ST_COMMIT = 5'b00100,
        ST_READ   = 5'b01000,
        ST_SINGLE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             mode_reg, mode_next;
    btk_pkg::entry_t        item_reg, item_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic [31:0]            offered_reg, offered_next;
    logic [6:0]             max_kept_reg, max_kept_next;
    logic [IDX_W-1:0]       read_cnt_reg, read_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    btk_pkg::res_word_t     out_word_reg, out_word_next;

    btk_pkg::cell_ctl_t     cell_ctl;
    btk_pkg::entry_t        cell_entry [CAPACITY];
    logic [CAPACITY-1:0]    ahead_vec;

    logic                   out_free;
    logic [CNT_W-1:0]       lim;
    logic [CNT_W-1:0]       pos;
    logic                   drop;
    logic                   read_last;
    logic [31:0]            offered_inc;

    // Effective list limit of a register value
    function automatic logic [CNT_W-1:0] limit_of(input logic [6:0] v);
        if (v == 7'd0)
        begin
            return CNT_W'(1);
        end
        if (32'(v) > 32'(CAPACITY))
        begin
            return CNT_W'(CAPACITY);
        end
        return CNT_W'(v);
    endfunction

    // Assemble a result word
    function automatic btk_pkg::res_word_t make_word(
        input logic              valid_res,
        input logic [CNT_W-1:0]  rank,
        input btk_pkg::entry_t   e,
        input logic [CNT_W-1:0]  held,
        input logic [31:0]       offered,
        input logic              last
    );
        btk_pkg::res_word_t w;
        w.valid_res    = valid_res;
        w.rank         = valid_res ? 6'(rank) : 6'd0;
        w.out_score    = valid_res ? e.score : 7'd0;
        w.out_kind     = valid_res ? e.kind : 2'd0;
        w.out_entry_id = valid_res ? e.id : 32'd0;
        w.out_tag      = valid_res ? e.tag : 4'd0;
        w.held_count   = 7'(held);
        w.truncated    = offered > 32'(held);
        w.last         = last;
        return w;
    endfunction

    // Cell row
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
        localparam int RIGHT = (gi == CAPACITY - 1) ? gi : gi + 1;

        btk_cell #(
            .IDX   (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .held        (held_reg),
            .left_entry  (cell_entry[LEFT]),
            .left_ahead  ((gi == 0) ? 1'b0 : ahead_vec[LEFT]),
            .right_entry (cell_entry[RIGHT]),
            .head_entry  (cell_entry[0]),
            .entry       (cell_entry[gi]),
            .ahead       (ahead_vec[gi])
        );
    end

    // Locate the insert position: the flags form a thermometer, count its zeros
    always_comb
    begin
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] cand;
        lo = '0;
        for (int k = CNT_W - 1; k >= 0; k--)
        begin
            cand = lo | (CNT_W'(1) << k);
            if (cand <= CNT_W'(CAPACITY)
                && !ahead_vec[IDX_W'(cand - CNT_W'(1))])
            begin
                lo = cand;
            end
        end
        pos = lo;
    end

    assign lim         = limit_of(max_kept_reg);
    assign drop        = (held_reg >= lim) && (pos >= held_reg);
    assign read_last   = (CNT_W'(read_cnt_reg) + CNT_W'(1)) == held_reg;
    assign offered_inc = (offered_reg == 32'hFFFF_FFFF) ? offered_reg
                                                         : offered_reg + 32'd1;
    assign out_free    = !out_valid_reg || res.ready;
    assign req.ready   = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        item_next      = item_reg;
        held_next      = held_reg;
        offered_next   = offered_reg;
        max_kept_next  = max_kept_reg;
        read_cnt_next  = read_cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_word_next  = out_word_reg;
        cell_ctl.op    = btk_pkg::CELL_HOLD;
        cell_ctl.item  = item_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next      = req.mode;
                    item_next      = '{score: req.score, kind: req.kind_code,
                                       id: req.item_id, tag: req.key_tag};
                    read_cnt_next  = '0;
                    case (req.mode)
                        btk_pkg::MODE_INSERT: state_next = ST_EVAL;
                        btk_pkg::MODE_READ:
                            state_next = (held_reg == '0) ? ST_SINGLE : ST_READ;
                        default:              state_next = ST_SINGLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                cell_ctl.op = btk_pkg::CELL_EVAL;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    offered_next   = offered_inc;
                    out_valid_next = 1'b1;
                    if (drop)
                    begin
                        out_word_next = make_word(1'b0, '0, item_reg, held_reg,
                                                  offered_inc, 1'b1);
                    end
                    else
                    begin
                        cell_ctl.op = btk_pkg::CELL_INSERT;
                        held_next   = (held_reg >= lim) ? held_reg
                                                        : held_reg + CNT_W'(1);
                        out_word_next = make_word(1'b1, pos, item_reg, held_next,
                                                  offered_inc, 1'b1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    cell_ctl.op    = btk_pkg::CELL_ROTATE;
                    out_valid_next = 1'b1;
                    out_word_next  = make_word(1'b1, CNT_W'(read_cnt_reg),
                                               cell_entry[0], held_reg,
                                               offered_reg, read_last);
                    read_cnt_next  = read_cnt_reg + IDX_W'(1);
                    if (read_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    if (mode_reg == btk_pkg::MODE_CLEAR)
                    begin
                        held_next    = '0;
                        offered_next = '0;
                    end
                    out_valid_next = 1'b1;
                    out_word_next  = make_word(1'b0, '0, item_reg, held_next,
                                               offered_next, 1'b1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Take a limit write and trim the list to it
        if (cfg_write)
        begin
            max_kept_next = cfg_data;
            if (held_reg > limit_of(cfg_data))
            begin
                held_next = limit_of(cfg_data);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            offered_reg   <= '0;
            max_kept_reg  <= btk_pkg::MAX_KEPT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            offered_reg   <= offered_next;
            max_kept_reg  <= max_kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        item_reg     <= item_next;
        read_cnt_reg <= read_cnt_next;
        out_word_reg <= out_word_next;
    end

    // Drive the result channel
    assign res.valid        = out_valid_reg;
    assign res.valid_res    = out_word_reg.valid_res;
    assign res.rank         = out_word_reg.rank;
    assign res.out_score    = out_word_reg.out_score;
    assign res.out_kind     = out_word_reg.out_kind;
    assign res.out_entry_id = out_word_reg.out_entry_id;
    assign res.out_tag      = out_word_reg.out_tag;
    assign res.held_count   = out_word_reg.held_count;
    assign res.truncated    = out_word_reg.truncated;
    assign res.last         = out_word_reg.last;

endmodule

// ===== tb/sv/bounded_top_k_ranked_list_test.sv =====
// ----------------------------------------------------------------------------
// bounded_top_k_ranked_list_test: self-checking bench of the ranked list
// Offers matches, read-outs, clears and the unused mode on the request
// channel, steps max_kept through its extremes while the block is idle, and
// checks every result word against a local model of the sorted list.
// Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module bounded_top_k_ranked_list_test;

    localparam int          LIST_DEPTH      = 64;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          TAIL_CYCLES     = 16;
    localparam int          WATCHDOG_LIMIT  = 4000;
    localparam int          PHASES          = 9;
    localparam int          ITEMS_PER_PHASE = 22;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [1:0]  KIND_FUZZY  = 2'd0;
    localparam logic [1:0]  KIND_ALIAS  = 2'd1;
    localparam logic [1:0]  KIND_EXACT  = 2'd2;
    localparam logic [1:0]  KIND_SPARE  = 2'd3;

    // One request word
    typedef struct packed {
        logic [1:0]       mode;
        btk_pkg::entry_t  e;
    } req_t;

    // One row of the directed plan: a limit write or a request word
    typedef struct packed {
        logic                is_limit;
        logic [6:0]          limit_val;
        logic                typed;
        req_t                item;
        btk_pkg::res_word_t  want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [6:0]  cfg_data;

    btk_req_if req_ch ();
    btk_res_if res_ch ();

    bounded_top_k_ranked_list #(
        .CAPACITY (LIST_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    // Local copy of the list state
    btk_pkg::entry_t     kept [LIST_DEPTH];
    int                  fill;
    logic [31:0]         offers;
    logic [6:0]          keep_limit;

    btk_pkg::res_word_t  expected_words [$];
    plan_row_t           plan [$];
    int                  error_count;
    int                  gap_pct;
    int                  stall_pct;
    int                  quiet_cycles;

    int unsigned phase_limit [PHASES] = '{64, 1, 127, 5, 0, 16, 2, 64, 40};

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------
    function automatic int tie_weight(input logic [1:0] kind);
        case (kind)
            KIND_EXACT: return 3;
            KIND_ALIAS: return 2;
            KIND_FUZZY: return 1;
            default:    return 0;
        endcase
    endfunction

    function automatic bit ranks_ahead(input btk_pkg::entry_t a, input btk_pkg::entry_t b);
        if (a.score != b.score)
            return a.score > b.score;
        if (tie_weight(a.kind) != tie_weight(b.kind))
            return tie_weight(a.kind) > tie_weight(b.kind);
        return a.id < b.id;
    endfunction

    function automatic int effective_limit();
        if (keep_limit == 7'd0)
            return 1;
        if (int'(keep_limit) > LIST_DEPTH)
            return LIST_DEPTH;
        return int'(keep_limit);
    endfunction

    function automatic void queue_word(input logic v, input int rank,
                                       input btk_pkg::entry_t e, input logic last);
        btk_pkg::res_word_t w;
        w.valid_res    = v;
        w.rank         = rank[5:0];
        w.out_score    = e.score;
        w.out_kind     = e.kind;
        w.out_entry_id = e.id;
        w.out_tag      = e.tag;
        w.held_count   = fill[6:0];
        w.truncated    = (offers > 32'(fill));
        w.last         = last;
        expected_words = {expected_words, w};
    endfunction

    function automatic void apply_limit(input logic [6:0] v);
        keep_limit = v;
        if (fill > effective_limit())
            fill = effective_limit();
    endfunction

    // Update the list for one accepted request and queue its result words
    function automatic void predict_list_item(input req_t it);
        int pos;
        int lim;
        int i;
        pos = 0;
        lim = effective_limit();
        if (it.mode == btk_pkg::MODE_INSERT)
        begin
            if (offers != 32'hFFFF_FFFF)
                offers++;
            while (pos < fill && !ranks_ahead(it.e, kept[pos]))
                pos++;
            if (fill >= lim && pos >= fill)
            begin
                queue_word(1'b0, 0, '0, 1'b1);
            end
            else
            begin
                // evict the tail when full, then shift down and place
                if (fill >= lim)
                    fill--;
                for (i = fill; i > pos; i--)
                    kept[i] = kept[i - 1];
                kept[pos] = it.e;
                fill++;
                queue_word(1'b1, pos, it.e, 1'b1);
            end
        end
        else if (it.mode == btk_pkg::MODE_READ && fill != 0)
        begin
            for (i = 0; i < fill; i++)
                queue_word(1'b1, i, kept[i], (i + 1 == fill));
        end
        else
        begin
            if (it.mode == btk_pkg::MODE_CLEAR)
            begin
                fill   = 0;
                offers = '0;
            end
            queue_word(1'b0, 0, '0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Plan rows
    // ------------------------------------------------------------------
    function automatic void add_row(input plan_row_t r);
        plan = {plan, r};
    endfunction

    function automatic plan_row_t item_row(input logic [1:0] mode, input logic [6:0] score,
                                           input logic [1:0] kind, input logic [31:0] id,
                                           input logic [3:0] tag);
        plan_row_t r;
        r = '0;
        r.item.mode    = mode;
        r.item.e.score = score;
        r.item.e.kind  = kind;
        r.item.e.id    = id;
        r.item.e.tag   = tag;
        return r;
    endfunction

    function automatic plan_row_t checked_row(input logic [1:0] mode, input logic [6:0] score,
                                              input logic [1:0] kind, input logic [31:0] id,
                                              input logic [3:0] tag,
                                              input btk_pkg::res_word_t want);
        plan_row_t r;
        r       = item_row(mode, score, kind, id, tag);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t limit_row(input logic [6:0] v);
        plan_row_t r;
        r           = '0;
        r.is_limit  = 1'b1;
        r.limit_val = v;
        return r;
    endfunction

    function automatic btk_pkg::res_word_t word_of(input logic v, input logic [5:0] rank,
                                                   input logic [6:0] score,
                                                   input logic [1:0] kind,
                                                   input logic [31:0] id,
                                                   input logic [3:0] tag,
                                                   input logic [6:0] held,
                                                   input logic trunc);
        btk_pkg::res_word_t w;
        w.valid_res    = v;
        w.rank         = rank;
        w.out_score    = score;
        w.out_kind     = kind;
        w.out_entry_id = id;
        w.out_tag      = tag;
        w.held_count   = held;
        w.truncated    = trunc;
        w.last         = 1'b1;
        return w;
    endfunction

    function automatic btk_pkg::res_word_t blank_word(input logic [6:0] held,
                                                      input logic trunc);
        return word_of(1'b0, '0, '0, '0, '0, '0, held, trunc);
    endfunction

    // Random request: mostly inserts, tie-heavy scores and ids
    function automatic req_t random_item();
        req_t it;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            it.mode = btk_pkg::MODE_INSERT;
        else if (pick < 93)
            it.mode = btk_pkg::MODE_READ;
        else if (pick < 97)
            it.mode = btk_pkg::MODE_CLEAR;
        else
            it.mode = MODE_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.e.score = 7'($urandom_range(60, 63));
        else if (pick < 90)
            it.e.score = 7'($urandom_range(0, 100));
        else
            it.e.score = 7'($urandom_range(101, 127));
        it.e.kind = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.e.id = $urandom_range(0, 7);
        else if (pick < 90)
            it.e.id = $urandom();
        else
            it.e.id = (pick < 95) ? 32'h0 : 32'hFFFF_FFFF;
        it.e.tag = 4'($urandom_range(0, 15));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic offer_word(input req_t it);
        // idle the sender at random before the word
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= it.mode;
        req_ch.score     <= it.e.score;
        req_ch.kind_code <= it.e.kind;
        req_ch.item_id   <= it.e.id;
        req_ch.key_tag   <= it.e.tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // Write max_kept only once the block has gone quiet
    task automatic write_limit(input logic [6:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= v;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        apply_limit(v);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0:
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1:
            begin
                gap_pct   = 62;
                stall_pct = 0;
            end
            2:
            begin
                gap_pct   = 0;
                stall_pct = 62;
            end
            default:
            begin
                gap_pct   = 13;
                stall_pct = 13;
            end
        endcase
    endtask

    // Stall the result channel at random, hold it low in reset
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : take_word
        btk_pkg::res_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word, rank %0d", res_ch.rank));
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("valid_res", 32'(res_ch.valid_res), 32'(want.valid_res));
                check_field("rank", 32'(res_ch.rank), 32'(want.rank));
                check_field("out_score", 32'(res_ch.out_score), 32'(want.out_score));
                check_field("out_kind", 32'(res_ch.out_kind), 32'(want.out_kind));
                check_field("out_entry_id", res_ch.out_entry_id, want.out_entry_id);
                check_field("out_tag", 32'(res_ch.out_tag), 32'(want.out_tag));
                check_field("held_count", 32'(res_ch.held_count), 32'(want.held_count));
                check_field("truncated", 32'(res_ch.truncated), 32'(want.truncated));
                check_field("last", 32'(res_ch.last), 32'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[bounded_top_k_ranked_list] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int        p;
        int        n;
        plan_row_t r;

        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = btk_pkg::MODE_INSERT;
        req_ch.score     = '0;
        req_ch.kind_code = '0;
        req_ch.item_id   = '0;
        req_ch.key_tag   = '0;
        error_count      = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        fill             = 0;
        offers           = '0;
        keep_limit       = btk_pkg::MAX_KEPT_RESET;

        // Directed plan: empty list, ties, extremes, limit changes, clears
        add_row(checked_row(btk_pkg::MODE_READ, 7'd0, KIND_FUZZY, 32'h0, 4'h0,
                            blank_word(7'd0, 1'b0)));
        add_row(checked_row(MODE_UNUSED, 7'd127, KIND_SPARE, 32'hFFFF_FFFF, 4'hF,
                            blank_word(7'd0, 1'b0)));
        add_row(checked_row(btk_pkg::MODE_INSERT, 7'd100, KIND_EXACT, 32'hFFFF_FFFF, 4'hF,
                            word_of(1'b1, 6'd0, 7'd100, KIND_EXACT, 32'hFFFF_FFFF,
                                    4'hF, 7'd1, 1'b0)));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd0, KIND_FUZZY, 32'h0, 4'h0));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd100, KIND_EXACT, 32'h0, 4'h5));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd100, KIND_EXACT, 32'h0, 4'h9));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd127, KIND_FUZZY, 32'h7, 4'h3));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd50, KIND_ALIAS, 32'd12, 4'h1));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd50, KIND_FUZZY, 32'd12, 4'h2));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd50, KIND_SPARE, 32'd12, 4'h3));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd50, KIND_EXACT, 32'd12, 4'h4));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd50, KIND_ALIAS, 32'd11, 4'h6));
        add_row(item_row(btk_pkg::MODE_READ, 7'd0, KIND_FUZZY, 32'h0, 4'h0));
        add_row(item_row(MODE_UNUSED, 7'd9, KIND_ALIAS, 32'd3, 4'hA));
        // lowering the limit below the fill level discards the tail
        add_row(limit_row(7'd3));
        add_row(item_row(btk_pkg::MODE_READ, 7'd0, KIND_FUZZY, 32'h0, 4'h0));
        add_row(checked_row(btk_pkg::MODE_INSERT, 7'd0, KIND_SPARE, 32'hFFFF_FFFF, 4'h0,
                            blank_word(7'd3, 1'b1)));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd127, KIND_EXACT, 32'h0, 4'h8));
        add_row(checked_row(btk_pkg::MODE_CLEAR, 7'd0, KIND_FUZZY, 32'h0, 4'h0,
                            blank_word(7'd0, 1'b0)));
        // a zero limit acts as one
        add_row(limit_row(7'd0));
        add_row(checked_row(btk_pkg::MODE_INSERT, 7'd20, KIND_ALIAS, 32'd5, 4'hA,
                            word_of(1'b1, 6'd0, 7'd20, KIND_ALIAS, 32'd5, 4'hA,
                                    7'd1, 1'b0)));
        add_row(checked_row(btk_pkg::MODE_INSERT, 7'd20, KIND_ALIAS, 32'd5, 4'hB,
                            blank_word(7'd1, 1'b1)));
        add_row(item_row(btk_pkg::MODE_INSERT, 7'd21, KIND_FUZZY, 32'd9, 4'hC));
        // a limit above the depth acts as the depth
        add_row(limit_row(7'd127));
        add_row(item_row(btk_pkg::MODE_READ, 7'd0, KIND_FUZZY, 32'h0, 4'h0));
        add_row(checked_row(btk_pkg::MODE_CLEAR, 7'd33, KIND_EXACT, 32'd1, 4'h1,
                            blank_word(7'd0, 1'b0)));

        // Hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan
        foreach (plan[i])
        begin
            r = plan[i];
            if (r.is_limit)
            begin
                write_limit(r.limit_val);
            end
            else
            begin
                offer_word(r.item);
                predict_list_item(r.item);
                if (r.typed)
                    expected_words[expected_words.size() - 1] = r.want;
            end
        end

        // Random phases, each with its own limit and idling pattern
        for (p = 0; p < PHASES; p++)
        begin
            write_limit(7'(phase_limit[p]));
            set_idling(p);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r.item = random_item();
                offer_word(r.item);
                predict_list_item(r.item);
            end
        end

        // Drain and let any stray word show up
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));

        if (error_count == 0)
            $display("[bounded_top_k_ranked_list] OK");
        else
            $display("[bounded_top_k_ranked_list] ERROR");
        $finish;
    end

endmodule
